[hw/rtl/dqap_pkg.sv]
// Package: character codes, limits and payload types of the dotted-quad parser.
package dqap_pkg;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_DOT  = 8'h2E;

  localparam logic [9:0] OCTET_MAX   = 10'd255;
  localparam logic [2:0] DOTS_NEEDED = 3'd3;
  localparam logic [2:0] DOTS_SAT    = 3'd4;
  localparam logic [1:0] DIGITS_MAX  = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } chr_item_t;

  typedef struct packed {
    logic [31:0] address;
    logic        valid_res;
    logic        mask_ok;
  } res_item_t;

endpackage

[hw/rtl/dqap_if.sv]
// Interfaces: character input channel and result output channel.
interface dqap_chr_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface dqap_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] address;
  logic        valid_res;
  logic        mask_ok;

  modport source (output valid, output address, output valid_res, output mask_ok,
                  input ready);
  modport sink   (input valid, input address, input valid_res, input mask_ok,
                  output ready);
endinterface

[hw/rtl/dqap_parse.sv]
// Parser state and per-character update, with the end-of-address result.
module dqap_parse
  import dqap_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  chr_item_t item_i,
  output res_item_t result_o
);

  logic [9:0]  octet_q, octet_d;
  logic [1:0]  digits_q, digits_d;
  logic [2:0]  dots_q, dots_d;
  logic [23:0] prefix_q, prefix_d;
  logic        err_q, err_d;

  logic        is_digit;
  logic        is_dot;
  logic        ok;
  logic [31:0] addr;
  logic [31:0] addr_ones;

  always_comb begin
    is_digit = item_i.char_code inside {[CH_ZERO:CH_NINE]};
    is_dot   = (item_i.char_code == CH_DOT);
    octet_d  = octet_q;
    digits_d = digits_q;
    dots_d   = dots_q;
    prefix_d = prefix_q;
    err_d    = err_q;
    if (!err_q) begin
      if (is_digit) begin
        if (digits_q == DIGITS_MAX) begin
          err_d = 1'b1;
        end else begin
          // x*10 + d; octet stays below 100 here, so 10 bits suffice
          octet_d  = {octet_q[6:0], 3'b000} + {octet_q[8:0], 1'b0}
                     + {6'd0, item_i.char_code[3:0]};
          digits_d = digits_q + 2'd1;
        end
      end else if (is_dot) begin
        if (digits_q == 2'd0 || octet_q > OCTET_MAX) begin
          err_d = 1'b1;
        end else begin
          if (dots_q < DOTS_NEEDED) begin
            prefix_d = {prefix_q[15:0], octet_q[7:0]};
          end
          if (dots_q < DOTS_SAT) begin
            dots_d = dots_q + 3'd1;
          end
          octet_d  = '0;
          digits_d = '0;
        end
      end else begin
        err_d = 1'b1;
      end
    end
  end

  // result from the state after this character
  always_comb begin
    ok        = !err_d && (dots_d == DOTS_NEEDED) && (digits_d != 2'd0)
                && (octet_d <= OCTET_MAX);
    addr      = ok ? {prefix_d, octet_d[7:0]} : 32'd0;
    // leading-ones test: every set bit has a set bit above it (or is the MSB)
    addr_ones = {1'b1, addr[31:1]} & addr;
    result_o.address   = addr;
    result_o.valid_res = ok;
    result_o.mask_ok   = ok && (addr != 32'd0) && (addr_ones == addr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      octet_q  <= '0;
      digits_q <= '0;
      dots_q   <= '0;
      prefix_q <= '0;
      err_q    <= 1'b0;
    end else if (step_i) begin
      if (item_i.last) begin
        octet_q  <= '0;
        digits_q <= '0;
        dots_q   <= '0;
        prefix_q <= '0;
        err_q    <= 1'b0;
      end else begin
        octet_q  <= octet_d;
        digits_q <= digits_d;
        dots_q   <= dots_d;
        prefix_q <= prefix_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

[hw/rtl/dotted_quad_address_parser_core.sv]
// Top level: dotted-decimal IPv4 address parser, one character per transaction.
// The last character waits in the input register; its result is then captured in the output register.
// Throughput: one character per cycle, set by the single parse stage.
// While a result waits at the output only a held last character stalls the input.
// Reset (rst_ni low, asynchronous) clears parser state and both valid flags.
module dotted_quad_address_parser_core
  import dqap_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  dqap_chr_if.sink   chr_i,
  dqap_res_if.source res_o
);

  // Input stage: registered character transaction
  logic      in_vld_q;
  chr_item_t in_item_q;

  // Output stage: registered result transaction
  logic      out_vld_q;
  res_item_t out_item_q;

  logic      in_adv;   // input stage hands its character to the parser
  logic      out_free; // output register can take a new result
  res_item_t parse_res;

  // A character without last never produces a result, so only last needs room
  assign out_free = !out_vld_q || res_o.ready;
  assign in_adv   = in_vld_q && (!in_item_q.last || out_free);
  assign chr_i.ready = !in_vld_q || in_adv;

  dqap_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (in_adv),
    .item_i   (in_item_q),
    .result_o (parse_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (chr_i.ready) begin
      in_vld_q <= chr_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chr_i.ready && chr_i.valid) begin
      in_item_q.char_code <= chr_i.char_code;
      in_item_q.last      <= chr_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_adv && in_item_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && in_item_q.last) begin
      out_item_q <= parse_res;
    end
  end

  assign res_o.valid     = out_vld_q;
  assign res_o.address   = out_item_q.address;
  assign res_o.valid_res = out_item_q.valid_res;
  assign res_o.mask_ok   = out_item_q.mask_ok;

endmodule

[sim/dqap_checker.sv]
`timescale 1ns / 1ps
// Checker for the dotted-quad parser: predicts each parse result and compares.
module dqap_checker
  import dqap_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  dqap_chr_if  chr_mon,
  dqap_res_if  res_mon,
  output int   fail_count_o,
  output int   pending_o
);

  // Shadow of the parser state.
  logic [9:0]  octet_acc;
  logic [1:0]  digit_cnt;
  logic [2:0]  dot_cnt;
  logic [23:0] prefix_acc;
  logic        bad_seen;

  res_item_t   parse_q[$];
  int          mismatches;

  // Nonzero run of leading ones followed only by zeros.
  function automatic logic is_mask(input logic [31:0] a);
    logic [31:0] inv;
    inv = ~a;
    return (a != '0) && ((inv & (inv + 32'd1)) == '0);
  endfunction

  task clear_parse();
    octet_acc  = '0;
    digit_cnt  = '0;
    dot_cnt    = '0;
    prefix_acc = '0;
    bad_seen   = 1'b0;
  endtask

  // Advance the shadow state by one character; queue a result on the last one.
  task parse_char(input logic [7:0] c, input logic fin);
    res_item_t r;
    logic      ok;
    if (!bad_seen) begin
      if (c >= CH_ZERO && c <= CH_NINE) begin
        if (digit_cnt == DIGITS_MAX) begin
          bad_seen = 1'b1;
        end else begin
          octet_acc = octet_acc * 10'd10 + 10'(c - CH_ZERO);
          digit_cnt = digit_cnt + 2'd1;
        end
      end else if (c == CH_DOT) begin
        if (digit_cnt == '0 || octet_acc > OCTET_MAX) begin
          bad_seen = 1'b1;
        end else begin
          if (dot_cnt < DOTS_NEEDED) prefix_acc = {prefix_acc[15:0], octet_acc[7:0]};
          if (dot_cnt < DOTS_SAT) dot_cnt = dot_cnt + 3'd1;
          octet_acc = '0;
          digit_cnt = '0;
        end
      end else begin
        bad_seen = 1'b1;
      end
    end
    if (fin) begin
      ok = !bad_seen && dot_cnt == DOTS_NEEDED && digit_cnt != '0 && octet_acc <= OCTET_MAX;
      r.address   = ok ? {prefix_acc, octet_acc[7:0]} : '0;
      r.valid_res = ok;
      r.mask_ok   = ok && is_mask(r.address);
      parse_q.push_back(r);
      clear_parse();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_item_t want;
    if (!rst_ni) begin
      clear_parse();
      parse_q.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (chr_mon.valid && chr_mon.ready) parse_char(chr_mon.char_code, chr_mon.last);
      if (res_mon.valid && res_mon.ready) begin
        if (parse_q.size() == 0) begin
          $display("%0t: unexpected result: address %h valid_res %b mask_ok %b",
                   $time, res_mon.address, res_mon.valid_res, res_mon.mask_ok);
          mismatches++;
        end else begin
          want = parse_q.pop_front();
          if (res_mon.address !== want.address) begin
            $display("%0t: address mismatch: expected %h actual %h",
                     $time, want.address, res_mon.address);
            mismatches++;
          end
          if (res_mon.valid_res !== want.valid_res) begin
            $display("%0t: valid_res mismatch: expected %b actual %b",
                     $time, want.valid_res, res_mon.valid_res);
            mismatches++;
          end
          if (res_mon.mask_ok !== want.mask_ok) begin
            $display("%0t: mask_ok mismatch: expected %b actual %b",
                     $time, want.mask_ok, res_mon.mask_ok);
            mismatches++;
          end
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= parse_q.size();
    end
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Testbench top: drives address text into the parser, stalls results, gives the verdict.
module testbench;
  import dqap_pkg::*;

  localparam int unsigned RANDOM_CHARS = 980;
  // No idling on either side once this few random characters remain.
  localparam int unsigned CALM_TAIL    = 120;
  // The limit sits far above the worst case, in which every transaction waits
  // behind the longest gap or stall; this leaves a wide margin.
  localparam int unsigned CYCLE_LIMIT  = 400000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int          fail_count;
  int          pending;
  int unsigned cycle_cnt = 0;

  // Idle control, re-rolled at random between addresses so that stretches with and without gaps occur.
  logic        calm = 1'b0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;

  // Text of the address under construction.
  logic [7:0]  text_q[$];
  int unsigned random_sent = 0;

  dqap_chr_if chr_if ();
  dqap_res_if res_if ();

  dotted_quad_address_parser_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .chr_i  (chr_if),
    .res_o  (res_if)
  );

  dqap_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .chr_mon      (chr_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Result side backpressure: random bursts with ready held low.
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      res_if.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      res_if.ready <= 1'b0;
      hold_left    <= $urandom_range(0, 17);
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // One character transaction. Entered and left at a falling edge; valid stays
  // high between back-to-back characters, so it is never dropped and raised in
  // the same step.
  task automatic send_char(input logic [7:0] c, input logic fin);
    int unsigned gap;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 18);
      chr_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    chr_if.valid     <= 1'b1;
    chr_if.char_code <= c;
    chr_if.last      <= fin;
    do @(posedge clk_i); while (!chr_if.ready);
    @(negedge clk_i);
  endtask

  // Stream the buffered text; the final character carries last.
  task automatic send_text();
    int unsigned n;
    n = text_q.size();
    for (int unsigned i = 0; i < n; i++) send_char(text_q[i], i == n - 1);
    text_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Decimal octet, optionally zero-padded; values up to 999 give the too-large case.
  task automatic add_octet(input int unsigned v, input int unsigned pad);
    logic [7:0] d2, d1, d0;
    d2 = CH_ZERO + 8'(v / 100);
    d1 = CH_ZERO + 8'((v / 10) % 10);
    d0 = CH_ZERO + 8'(v % 10);
    if (v >= 100 || pad >= 2) text_q.push_back(d2);
    if (v >= 10 || pad >= 1) text_q.push_back(d1);
    text_q.push_back(d0);
  endtask

  function automatic logic [7:0] digit_or_dot();
    return ($urandom_range(0, 2) == 0) ? CH_DOT : CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Random address text: mostly well-formed dotted quads (a share of them masks),
  // some with an octet above 255, some damaged after the fact, the rest character noise.
  task automatic build_random_text();
    int unsigned kind, plen, pos, nch;
    int unsigned oct[4];
    logic [31:0] mask;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      if (kind < 15) begin
        plen = $urandom_range(0, 32);
        mask = (plen == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - plen));
        // Near-masks: one flipped bit breaks contiguity unless it sits at the edge of the run.
        if (kind < 4) mask[$urandom_range(0, 31)] ^= 1'b1;
        for (int i = 0; i < 4; i++) oct[i] = mask[31 - 8 * i -: 8];
      end else begin
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(0, 9))
            0:       oct[i] = 0;
            1:       oct[i] = 255;
            default: oct[i] = $urandom_range(0, 255);
          endcase
        end
      end
      // Octet above 255 somewhere.
      if (kind >= 60 && kind < 66) oct[$urandom_range(0, 3)] = $urandom_range(256, 999);
      for (int i = 0; i < 4; i++) begin
        if (i != 0) text_q.push_back(CH_DOT);
        add_octet(oct[i], ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
      end
      if (kind >= 66) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 4))
          0: text_q[pos] = 8'($urandom_range(0, 255));
          1: text_q.delete(pos);
          2: text_q.insert(pos, digit_or_dot());
          3: begin
            text_q.push_back(CH_DOT);
            add_octet($urandom_range(0, 255), 0);
          end
          default: begin
            nch = $urandom_range(1, 4);
            repeat (nch) if (text_q.size() > 1) void'(text_q.pop_back());
          end
        endcase
      end
    end else begin
      nch = $urandom_range(1, 12);
      repeat (nch) begin
        if ($urandom_range(0, 99) < 65) text_q.push_back(digit_or_dot());
        else text_q.push_back(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    chr_if.valid     = 1'b0;
    chr_if.char_code = '0;
    chr_if.last      = 1'b0;
    res_if.ready     = 1'b0;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: widest octets and a mask, all-zero address, dot count
    // saturation, too-large octet at a dot and at the end, fourth digit,
    // empty octets, too few dots, bad characters on both sides of the digits.
    add_text("255.255.255.0"); send_text();
    add_text("0.0.0.0");       send_text();
    add_text("1.2.3.4.5.6");   send_text();
    add_text("256.1..9");      send_text();
    add_text("1.2.3.1000");    send_text();
    add_text("7.7.7.300");     send_text();
    add_text("1.2.3.");        send_text();
    add_text("1..2");          send_text();
    add_text("8.8.8");         send_text();
    text_q.push_back(CH_NINE); text_q.push_back(CH_ZERO - 8'd1); send_text();
    text_q.push_back(CH_NINE + 8'd1); send_text();
    text_q.push_back(8'h00); text_q.push_back(8'hFF); send_text();
    text_q.push_back(CH_DOT); send_text();

    // Random part; the tail runs with both sides idle-free.
    while (random_sent < RANDOM_CHARS) begin
      calm = (random_sent + CALM_TAIL >= RANDOM_CHARS);
      if (!calm && $urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: begin gap_pct = 0;  stall_pct = 0;  end
          1: begin gap_pct = 5;  stall_pct = 10; end
          2: begin gap_pct = 20; stall_pct = 5;  end
          default: begin gap_pct = 40; stall_pct = 40; end
        endcase
      end
      build_random_text();
      random_sent += text_q.size();
      send_text();
    end
    chr_if.valid <= 1'b0;

    // Drain: the watchdog bounds this wait.
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
